@@ hw/rtl/itf_pkg.sv @@
package itf_pkg;

  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_MAX_FIELD  = 60;

  localparam int MAX_DIGITS  = 22;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int FIELD_W     = 6;
  localparam int POS_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  typedef struct packed {
    logic [63:0]        magnitude;
    logic               is_negative;
    logic [1:0]         radix_sel;
    logic               upper_case;
    logic               left_justify;
    logic               plus_sign;
    logic               space_sign;
    logic               alt_form;
    logic               zero_fill;
    logic               precision_given;
    logic [FIELD_W-1:0] precision;
    logic [FIELD_W-1:0] width;
  } itf_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } itf_rsp_t;

  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [DIGIT_CNT_W-1:0]     ndig;
    logic                       is_negative;
    logic                       is_oct;
    logic                       is_hex;
    logic                       upper_case;
    logic                       left_justify;
    logic                       plus_sign;
    logic                       space_sign;
    logic                       alt_form;
    logic                       zero_fill;
    logic                       precision_given;
    logic [FIELD_W-1:0]         precision;
    logic [FIELD_W-1:0]         width;
  } itf_job_t;

  function automatic logic [7:0] itf_digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

@@ hw/rtl/integer_to_text_formatter_top.sv @@
// Integer to text formatter: printf-style integer conversion.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one conversion
// request: magnitude, sign flags, radix, case, justification, zero fill,
// precision and width. Output channel (out_valid_o / out_stall_i /
// out_data_o) returns the field one ASCII character per item, most
// significant first, with last_char set on the final character.
// The front converts the value: hex and octal load the digits directly,
// decimal runs a binary-to-BCD converter at 4 bits per cycle, then
// leading zero digits are dropped one per cycle. A two-entry queue holds
// converted requests, so the front can accept a new request while the
// back is still emitting an earlier field. The back loads a request from
// the queue and then emits one character per cycle while the receiver
// does not stall.
// Reset clears both state machines, the queue and the output valid flag.
// When the receiver stalls, the output register holds its character, the
// back halts, the queue fills and in_stall_o rises once the front is busy.
module integer_to_text_formatter_top #(
  parameter int VALUE_BITS = itf_pkg::DEF_VALUE_BITS,
  parameter int MAX_FIELD  = itf_pkg::DEF_MAX_FIELD
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  itf_pkg::itf_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output itf_pkg::itf_rsp_t out_data_o
);
  import itf_pkg::*;

  itf_job_t front_job;
  itf_job_t queue_job;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  itf_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (front_job),
    .full_i    (full)
  );

  itf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_job),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (queue_job)
  );

  itf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (queue_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ hw/rtl/itf_front.sv @@
module itf_front #(
  parameter int VALUE_BITS = itf_pkg::DEF_VALUE_BITS,
  parameter int MAX_FIELD  = itf_pkg::DEF_MAX_FIELD
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  itf_pkg::itf_req_t in_data_i,
  output logic             push_o,
  output itf_pkg::itf_job_t job_o,
  input  logic             full_i
);
  import itf_pkg::*;

  localparam int DecDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OctDigits = (VALUE_BITS + 2) / 3;
  localparam int HexDigits = (VALUE_BITS + 3) / 4;
  localparam int Steps     = (VALUE_BITS + 3) / 4;
  localparam int BinW      = Steps * 4;
  localparam int StepW     = $clog2(Steps + 1);
  localparam int DigW      = MAX_DIGITS * 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_NORM = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [BinW-1:0]  bin_q, bin_d;
  itf_job_t         job_q, job_d;

  logic [DigW-1:0]       hex_digits;
  logic [DigW-1:0]       oct_digits;
  logic [MAX_DIGITS*3-1:0] oct_bits;
  logic [DigW-1:0]       conv_digits;
  logic [3:0]            top_digit;

  function automatic logic [DigW-1:0] dabble(input logic [DigW-1:0] b, input logic bit_in);
    logic [DigW-1:0] r;
    r = b;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (r[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
    end
    return {r[DigW-2:0], bit_in};
  endfunction

  function automatic logic [FIELD_W-1:0] sat_field(input logic [FIELD_W-1:0] v);
    return (int'(v) > MAX_FIELD) ? FIELD_W'(MAX_FIELD) : v;
  endfunction

  assign hex_digits = DigW'(in_data_i.magnitude[VALUE_BITS-1:0]);
  assign oct_bits   = (MAX_DIGITS * 3)'(in_data_i.magnitude[VALUE_BITS-1:0]);

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      oct_digits[4*i +: 4] = {1'b0, oct_bits[3*i +: 3]};
    end
  end

  always_comb begin
    conv_digits = job_q.digits;
    for (int j = 0; j < 4; j++) begin
      conv_digits = dabble(conv_digits, bin_q[BinW-1-j]);
    end
  end

  assign top_digit = job_q.digits[DIGIT_IDX_W'(job_q.ndig - 1'b1)];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    job_d   = job_q;
    push_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          job_d.is_negative     = in_data_i.is_negative;
          job_d.is_oct          = (in_data_i.radix_sel == RADIX_OCT);
          job_d.is_hex          = (in_data_i.radix_sel == RADIX_HEX);
          job_d.upper_case      = in_data_i.upper_case;
          job_d.left_justify    = in_data_i.left_justify;
          job_d.plus_sign       = in_data_i.plus_sign;
          job_d.space_sign      = in_data_i.space_sign;
          job_d.alt_form        = in_data_i.alt_form;
          job_d.zero_fill       = in_data_i.zero_fill;
          job_d.precision_given = in_data_i.precision_given;
          job_d.precision       = sat_field(in_data_i.precision);
          job_d.width           = sat_field(in_data_i.width);
          case (in_data_i.radix_sel)
            RADIX_HEX: begin
              job_d.digits = hex_digits;
              job_d.ndig   = DIGIT_CNT_W'(HexDigits);
              state_d      = S_NORM;
            end
            RADIX_OCT: begin
              job_d.digits = oct_digits;
              job_d.ndig   = DIGIT_CNT_W'(OctDigits);
              state_d      = S_NORM;
            end
            default: begin
              job_d.digits = '0;
              job_d.ndig   = DIGIT_CNT_W'(DecDigits);
              bin_d        = BinW'(in_data_i.magnitude[VALUE_BITS-1:0]);
              cnt_d        = StepW'(Steps);
              state_d      = S_CONV;
            end
          endcase
        end
      end
      S_CONV: begin
        job_d.digits = conv_digits;
        bin_d        = bin_q << 4;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (job_q.ndig > DIGIT_CNT_W'(1) && top_digit == 4'd0) begin
          job_d.ndig = job_q.ndig - 1'b1;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    job_q <= job_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign job_o      = job_q;

endmodule

@@ hw/rtl/itf_fifo.sv @@
module itf_fifo #(
  parameter int DEPTH = itf_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  itf_pkg::itf_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output itf_pkg::itf_job_t data_o
);
  import itf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  itf_job_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/itf_back.sv @@
module itf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  itf_pkg::itf_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output itf_pkg::itf_rsp_t out_data_o
);
  import itf_pkg::*;

  logic                      busy_q;
  logic [POS_W-1:0]          pos_q;
  logic                      out_valid_q;
  itf_rsp_t                  out_data_q;
  logic [MAX_DIGITS-1:0][3:0] digits_q;
  logic [DIGIT_CNT_W-1:0]    ndig_q;
  logic                      upper_q;
  logic [2:0][7:0]           head_q;
  logic [POS_W-1:0]          b1_q, b2_q, b3_q, b4_q, len_q;

  logic                      has_sign;
  logic [7:0]                sign_ch, x_ch;
  logic [2:0][7:0]           head_d;
  logic [POS_W-1:0]          nhead, npfx, ndig_eff, body, pad, b1, b2, b3, b4;
  logic [POS_W-1:0]          k;
  logic [7:0]                ch;
  logic                      last;
  logic                      adv;

  always_comb begin
    has_sign = job_i.is_negative | job_i.plus_sign | job_i.space_sign;
    sign_ch  = job_i.is_negative ? CH_MINUS : (job_i.plus_sign ? CH_PLUS : CH_SPACE);
    x_ch     = job_i.upper_case ? CH_UPPER_X : CH_LOWER_X;
    if (job_i.alt_form && job_i.is_hex) begin
      npfx = POS_W'(2);
    end else if (job_i.alt_form && job_i.is_oct) begin
      npfx = POS_W'(1);
    end else begin
      npfx = '0;
    end
    if (has_sign) begin
      head_d = {x_ch, CH_ZERO, sign_ch};
    end else begin
      head_d = {CH_SPACE, x_ch, CH_ZERO};
    end
    nhead = npfx + POS_W'(has_sign);
    if (job_i.precision_given && POS_W'(job_i.precision) > POS_W'(job_i.ndig)) begin
      ndig_eff = POS_W'(job_i.precision);
    end else begin
      ndig_eff = POS_W'(job_i.ndig);
    end
    body = nhead + ndig_eff;
    pad  = (POS_W'(job_i.width) > body) ? POS_W'(job_i.width) - body : '0;
    b1   = (!job_i.left_justify && !job_i.zero_fill) ? pad : '0;
    b2   = b1 + nhead;
    b3   = b2 + ((!job_i.left_justify && job_i.zero_fill) ? pad : '0);
    b4   = b3 + ndig_eff;
  end

  assign pop_o = !busy_q && !empty_i;
  assign adv   = busy_q && (!out_valid_q || !out_stall_i);
  assign k     = b4_q - 1'b1 - pos_q;
  assign last  = (pos_q == len_q - 1'b1);

  always_comb begin
    if (pos_q < b1_q) begin
      ch = CH_SPACE;
    end else if (pos_q < b2_q) begin
      ch = head_q[2'(pos_q - b1_q)];
    end else if (pos_q < b3_q) begin
      ch = CH_ZERO;
    end else if (pos_q < b4_q) begin
      if (k < POS_W'(ndig_q)) begin
        ch = itf_digit_char(digits_q[DIGIT_IDX_W'(k)], upper_q);
      end else begin
        ch = CH_ZERO;
      end
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (adv) begin
        pos_q <= pos_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digits_q <= job_i.digits;
      ndig_q   <= job_i.ndig;
      upper_q  <= job_i.upper_case;
      head_q   <= head_d;
      b1_q     <= b1;
      b2_q     <= b2;
      b3_q     <= b3;
      b4_q     <= b4;
      len_q    <= body + pad;
    end
    if (adv) begin
      out_data_q.out_char  <= ch;
      out_data_q.last_char <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
